[sv/bole_pkg.sv]
// shared constants, codes and controller/datapath interface types
// for the bounded ordered list engine; no dependencies
package bole_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 32;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // beat field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_FRONT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BACK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic shift_rd;
        logic shift_wr;
        logic list_init;
        logic list_rd;
        logic list_ld;
        logic list_step;
        logic empty_ld;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic shift_go;
        logic empty;
        logic last;
    } dp_stat_t;

endpackage

[sv/bounded_ordered_list_engine.sv]
// top level of the bounded ordered list engine: controller plus datapath
// depends on bole_pkg, bole_ctrl, bole_dp (and bole_ram through bole_dp)
//
//  channel  dir  tdata                          tuser                          tlast
//  s_*      in   [31:0] value, [37:32] position  [1:0] cmd                      -
//  m_*      out  [31:0] element                  [0] direction, [1] has_element, end of item
//                                                [3:2] status
//
// an item passes accept, execute and check; s entries shifted by a middle delete
// and r = 2*count result beats follow; an empty list yields a single marker beat
// one registered store read per shifted entry and per listed beat
// reset clears front pointer, count, shift flag and the controller; store contents stay undefined
// one item at a time: s_tready is low from acceptance until the last beat is taken
// a stalled m_tready holds the beat and the whole engine
module bounded_ordered_list_engine
    import bole_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] value, [37:32] position, zero fill
    input  logic [CMD_W-1:0]    s_tuser,   // [1:0] cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] element
    output logic [M_USER_W-1:0] m_tuser,   // [0] direction, [1] has_element, [3:2] status
    output logic                m_tlast
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencing
    bole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // list storage and output beat
    bole_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

[sv/bole_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/bole_dp.sv]
// datapath: list pointers, element store, shift and listing counters,
// output beat registers; depends on bole_pkg and bole_ram
module bole_dp
    import bole_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser,
    output logic                m_tlast
);

    // wrap an offset from a base index into the circular store
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [PTR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                shift_en_reg, shift_en_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                dir_reg, dir_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  out_elem_reg, out_elem_next;
    logic                out_dir_reg, out_dir_next;
    logic                out_has_reg, out_has_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                ram_wr_en;
    logic [PTR_W-1:0]    ram_wr_addr;
    logic [VALUE_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [PTR_W-1:0]    ram_rd_addr;
    logic [VALUE_W-1:0]  ram_rd_data;

    logic                full;
    logic [PTR_W-1:0]    front_dec;
    logic [CNT_W-1:0]    count_m1;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign front_dec = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - PTR_W'(1);
    assign count_m1  = count_reg - CNT_W'(1);

    // register updates driven by controller commands
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        shift_en_next   = shift_en_reg;
        idx_next        = idx_reg;
        dir_next        = dir_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        status_next     = status_reg;
        out_elem_next   = out_elem_reg;
        out_dir_next    = out_dir_reg;
        out_has_next    = out_has_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = front_reg;
        ram_wr_data     = value_reg;

        // capture the accepted beat
        if (cmd.load_item)
        begin
            cmd_next   = s_tuser;
            value_next = s_tdata[VALUE_W-1:0];
            pos_next   = s_tdata[VALUE_W +: POS_W];
        end

        // apply the command to the list
        if (cmd.exec)
        begin
            status_next   = ST_DONE;
            shift_en_next = 1'b0;
            case (cmd_reg)
                CMD_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_next  = front_dec;
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = front_dec;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                CMD_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = slot_of(front_reg, count_reg);
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (pos_reg >= POS_W'(count_reg))
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        if (pos_reg == '0)
                        begin
                            front_next = slot_of(front_reg, CNT_W'(1));
                        end
                        else
                        begin
                            shift_en_next = 1'b1;
                            idx_next      = CNT_W'(pos_reg);
                        end
                        count_next = count_m1;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end

        // move one later entry a place toward the front
        if (cmd.shift_wr)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_of(front_reg, idx_reg);
            ram_wr_data = ram_rd_data;
            idx_next    = idx_reg + CNT_W'(1);
        end

        // start the front to back listing
        if (cmd.list_init)
        begin
            shift_en_next = 1'b0;
            idx_next      = '0;
            dir_next      = 1'b0;
        end

        // load a listed element into the output beat
        if (cmd.list_ld)
        begin
            out_elem_next   = ram_rd_data;
            out_dir_next    = dir_reg;
            out_has_next    = 1'b1;
            out_status_next = status_reg;
            out_last_next   = dir_reg && (idx_reg == '0);
        end

        // empty list marker beat
        if (cmd.empty_ld)
        begin
            shift_en_next   = 1'b0;
            out_elem_next   = '0;
            out_dir_next    = 1'b0;
            out_has_next    = 1'b0;
            out_status_next = status_reg;
            out_last_next   = 1'b1;
        end

        // advance listing; the back end is listed twice, once each way
        if (cmd.list_step)
        begin
            if (!dir_reg)
            begin
                if (idx_reg == count_m1)
                begin
                    dir_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            else
            begin
                idx_next = idx_reg - CNT_W'(1);
            end
        end
    end

    // read address for shift and listing
    always_comb
    begin
        ram_rd_en   = cmd.shift_rd | cmd.list_rd;
        ram_rd_addr = slot_of(front_reg, idx_reg);
        if (cmd.shift_rd)
        begin
            ram_rd_addr = slot_of(front_reg, idx_reg + CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            shift_en_reg <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            shift_en_reg <= shift_en_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        dir_reg        <= dir_next;
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        status_reg     <= status_next;
        out_elem_reg   <= out_elem_next;
        out_dir_reg    <= out_dir_next;
        out_has_reg    <= out_has_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // element store
    bole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // status to controller
    assign stat.shift_go = shift_en_reg && (idx_reg < count_reg);
    assign stat.empty    = (count_reg == '0);
    assign stat.last     = out_last_reg;

    // output beat
    assign m_tdata = out_elem_reg;
    assign m_tuser = {out_status_reg, out_has_reg, out_dir_reg};
    assign m_tlast = out_last_reg;

endmodule

[sv/bole_ctrl.sv]
// controller state machine sequencing command, shift and listing steps
// depends on bole_pkg
module bole_ctrl
    import bole_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_EXEC  = 8'b00000010,
        ST_CHK   = 8'b00000100,
        ST_SHRD  = 8'b00001000,
        ST_SHWR  = 8'b00010000,
        ST_LSTRD = 8'b00100000,
        ST_LSTLD = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.shift_go)
                begin
                    state_next = ST_SHRD;
                end
                else if (stat.empty)
                begin
                    cmd.empty_ld = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.list_init = 1'b1;
                    state_next    = ST_LSTRD;
                end
            end
            ST_SHRD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = ST_SHWR;
            end
            ST_SHWR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_CHK;
            end
            ST_LSTRD:
            begin
                cmd.list_rd = 1'b1;
                state_next  = ST_LSTLD;
            end
            ST_LSTLD:
            begin
                cmd.list_ld = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.list_step = 1'b1;
                        state_next    = ST_LSTRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // handshake outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

endmodule
